[hdl/csd_pkg.sv]
package csd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W = 8;

   // Status codes carried with every result word.
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_END = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ERR = 2'd2;

   // Control register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH = 1'd1;

   localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'd0;
   localparam logic [BYTE_W-1:0] DEPTH_RESET = 8'd255;

   typedef struct packed {
      logic                valid;
      logic [BYTE_W-1:0]   out_byte;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

[hdl/csd_req_if.sv]
interface csd_req_if;
   import csd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

[hdl/csd_rsp_if.sv]
interface csd_rsp_if;
   import csd_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output out_byte, output status, input ready);
   modport sink (input valid, input out_byte, input status, output ready);
endinterface

[hdl/csd_decode_core.sv]
module csd_decode_core
   import csd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   csd_req_if.sink                req_chan,
   input  logic                   out_full,
   output result_type             res
);

   typedef enum logic [1:0] {
      MODE_SERVICE,
      MODE_REGULAR,
      MODE_SWAP,
      MODE_WAIT
   } mode_type;

   logic [BYTE_W-1:0] delim_ff;
   logic [BYTE_W-1:0] depth_ff;
   mode_type          mode_ff, mode_in;
   logic [BYTE_W-1:0] swap_ff, swap_in;
   logic [BYTE_W-1:0] svc_ff, svc_in;
   logic              hold_v_ff;
   logic [BYTE_W-1:0] hold_byte_ff;
   logic              advance;
   logic              is_delim;
   logic              over_depth;
   logic [BYTE_W-1:0] offset_val;
   result_type        res_in;

   assign advance = hold_v_ff && !out_full;
   assign req_chan.ready = !hold_v_ff || !out_full;

   assign is_delim = (hold_byte_ff == delim_ff);
   assign over_depth = (hold_byte_ff > depth_ff);
   // A zero offset stands for a nonzero delimiter value.
   assign offset_val = (hold_byte_ff == '0 && delim_ff != '0) ? delim_ff : hold_byte_ff;

   always_comb begin
      logic              step;
      logic [BYTE_W-1:0] swap_base;
      logic [BYTE_W-1:0] swap_dec;
      logic [BYTE_W-1:0] svc_dec;
      step = 1'b0;
      swap_base = swap_ff;
      swap_dec = '0;
      svc_dec = svc_ff - 1'b1;
      mode_in = mode_ff;
      swap_in = swap_ff;
      svc_in = svc_ff;
      res_in = '0;
      case (mode_ff)
         MODE_SERVICE: begin
            if (is_delim) begin
               mode_in = MODE_SERVICE;
               swap_in = '0;
               svc_in = depth_ff;
            end else if (over_depth) begin
               res_in = '{valid: 1'b1, out_byte: hold_byte_ff, status: ST_ERR};
               mode_in = MODE_WAIT;
            end else begin
               swap_base = offset_val;
               step = 1'b1;
            end
         end
         MODE_REGULAR: begin
            if (is_delim) begin
               res_in = '{valid: 1'b1, out_byte: hold_byte_ff, status: ST_ERR};
               mode_in = MODE_WAIT;
            end else begin
               res_in = '{valid: 1'b1, out_byte: hold_byte_ff, status: ST_OK};
               step = 1'b1;
            end
         end
         MODE_SWAP: begin
            if (is_delim) begin
               res_in = '{valid: 1'b1, out_byte: hold_byte_ff, status: ST_END};
               mode_in = MODE_SERVICE;
               swap_in = '0;
               svc_in = depth_ff;
            end else if (over_depth) begin
               res_in = '{valid: 1'b1, out_byte: hold_byte_ff, status: ST_ERR};
               mode_in = MODE_WAIT;
            end else begin
               res_in = '{valid: 1'b1, out_byte: delim_ff, status: ST_OK};
               swap_base = offset_val;
               step = 1'b1;
            end
         end
         default: begin
            if (is_delim) begin
               mode_in = MODE_SERVICE;
               swap_in = '0;
               svc_in = depth_ff;
            end
         end
      endcase
      if (step) begin
         swap_dec = swap_base - 1'b1;
         swap_in = swap_dec;
         // The service byte wins over a swap position landing on the same byte.
         if (svc_dec == '0) begin
            mode_in = MODE_SERVICE;
            svc_in = depth_ff;
         end else if (swap_dec == '0) begin
            mode_in = MODE_SWAP;
            svc_in = svc_dec;
         end else begin
            mode_in = MODE_REGULAR;
            svc_in = svc_dec;
         end
      end
   end

   assign res = '{valid: advance && res_in.valid, out_byte: res_in.out_byte,
                  status: res_in.status};

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIMITER_RESET;
         depth_ff <= DEPTH_RESET;
         mode_ff <= MODE_SERVICE;
         swap_ff <= '0;
         svc_ff <= DEPTH_RESET;
         hold_v_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DELIMITER: delim_ff <= csr_data;
               CSR_DEPTH: depth_ff <= csr_data;
               default: ;
            endcase
         end
         if (advance) begin
            mode_ff <= mode_in;
            swap_ff <= swap_in;
            svc_ff <= svc_in;
         end
         if (req_chan.ready) begin
            hold_v_ff <= req_chan.valid;
         end
      end
      if (req_chan.valid && req_chan.ready) begin
         hold_byte_ff <= req_chan.in_byte;
      end
   end

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (res.status == ST_OK || res.status == ST_END || res.status == ST_ERR))
      else $error("result with undefined status code");

   a_err_waits: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.status == ST_ERR) |=> mode_ff == MODE_WAIT)
      else $error("error result did not enter wait mode");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (res.valid && res.status == ST_END) |=> (mode_ff == MODE_SERVICE && swap_ff == '0))
      else $error("frame end did not restart the decoder");

endmodule

[hdl/csd_out_buffer.sv]
module csd_out_buffer
   import csd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type res,
   output logic       out_full,
   csd_rsp_if.source  rsp_chan
);

   logic [1:0]          count_ff, count_in;
   logic [BYTE_W-1:0]   byte0_ff, byte1_ff;
   logic [STATUS_W-1:0] status0_ff, status1_ff;
   logic                push;
   logic                pop;

   assign push = res.valid;
   assign pop = rsp_chan.valid && rsp_chan.ready;
   assign out_full = (count_ff == 2'd2);

   assign rsp_chan.valid = (count_ff != 2'd0);
   assign rsp_chan.out_byte = byte0_ff;
   assign rsp_chan.status = status0_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      // Slot 0 drives the port; slot 1 catches a word while slot 0 is stalled.
      if (pop) begin
         if (count_ff == 2'd2) begin
            byte0_ff <= byte1_ff;
            status0_ff <= status1_ff;
            if (push) begin
               byte1_ff <= res.out_byte;
               status1_ff <= res.status;
            end
         end else if (push) begin
            byte0_ff <= res.out_byte;
            status0_ff <= res.status;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            byte0_ff <= res.out_byte;
            status0_ff <= res.status;
         end else begin
            byte1_ff <= res.out_byte;
            status1_ff <= res.status;
         end
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output buffer count out of range");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !out_full)
      else $error("word pushed into a full output buffer");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - 2'd1)
      else $error("output buffer count did not follow a pop");

endmodule

[hdl/cobs_stream_decoder_top.sv]
// COBS-style stream decoder. Each received byte word on req_chan is decoded
// in a single pass and yields zero or one result word on rsp_chan, carrying
// the decoded byte and a status (0 data, 1 frame end, 2 decoding error).
// The block takes one byte per clock cycle in steady state; a byte is held
// in the input register, is decoded by the compare and counter logic behind
// it, and its result word is written into a two-word output buffer once that
// buffer has room, from where it is presented on rsp_chan. The only thing
// that slows intake is backpressure: req_chan.ready drops when the input
// register holds a byte and the output buffer is full. Service bytes,
// silent restarts and bytes dropped while waiting for a delimiter after an
// error produce no result word. The delimiter value (index 0, reset 0) and
// the block depth (index 1, reset 255) are written through the csr_ port;
// the user must do so only while the decoder is idle, which the block
// itself does not enforce. A new depth is used for range checks at once and
// loaded into the block countdown at the next service byte reload, silent
// restart, frame end or error recovery.
module cobs_stream_decoder_top
   import csd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   csd_req_if.sink                req_chan,
   csd_rsp_if.source              rsp_chan
);

   // Result of the decode step, valid only in a cycle where a byte advances.
   result_type res;
   // The output buffer has no room, so the held input byte must wait.
   logic       out_full;

   // Input register, control registers and the decode state machine.
   csd_decode_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_chan  (req_chan),
      .out_full  (out_full),
      .res       (res)
   );

   // Output register with one skid slot, so the response side can stall
   // without a combinational path back to req_chan.ready.
   csd_out_buffer u_out (
      .clock    (clock),
      .reset    (reset),
      .res      (res),
      .out_full (out_full),
      .rsp_chan (rsp_chan)
   );

endmodule

[dv/cobs_stream_decoder_top_test.sv]
module cobs_stream_decoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import csd_pkg::*;

   typedef logic [BYTE_W-1:0] octet_type;

   // One decoded word as it leaves the block: the byte and its status code.
   typedef struct packed {
      octet_type           out_byte;
      logic [STATUS_W-1:0] status;
   } decoded_type;

   // Where the decoder stands in the encoded stream.
   typedef enum logic [1:0] {
      AWAIT_SERVICE,
      IN_BLOCK,
      AT_SWAP,
      SKIP_FRAME
   } scan_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   csd_req_if req_chan();
   csd_rsp_if rsp_chan();

   cobs_stream_decoder_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Encoded bytes waiting to be driven, and the decoded words that the
   // predictor says must come out, oldest first.
   octet_type   pending_bytes[$];
   decoded_type expected_decodes[$];

   int unsigned queued_bytes   = 0;
   int unsigned mismatch_count = 0;

   // Percent chance per cycle that either side starts an idle burst.
   int unsigned idle_pct = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;

   // Set at each rising edge when the driven byte word was taken.
   logic req_took = 1'b0;

   // Predictor copy of the two registers and of the decoder state.
   octet_type delim_reg;
   octet_type depth_reg;
   scan_type  scan;
   octet_type swap_left;
   octet_type service_left;

   // A silent restart: back to expecting a service byte, and the block
   // countdown picks up whatever depth is programmed at this moment.
   function automatic void restart_scan();
      scan = AWAIT_SERVICE;
      swap_left = '0;
      service_left = depth_reg;
   endfunction

   // Loads an offset byte into the swap countdown. The range check works on
   // the raw byte; only afterwards does a zero byte stand for the delimiter
   // value (when the delimiter is nonzero). Returns 0 when out of range.
   function automatic bit accept_offset(input octet_type b);
      if (b > depth_reg)
         return 1'b0;
      if (b == 8'h00 && delim_reg != 8'h00)
         swap_left = delim_reg;
      else
         swap_left = b;
      return 1'b1;
   endfunction

   // Decodes one received byte and returns 1 when it yields a result word.
   function automatic bit decode_byte(input octet_type b, output decoded_type word);
      bit produced;
      bit advance;
      produced = 1'b0;
      advance = 1'b1;
      word = '0;
      case (scan)
         AWAIT_SERVICE: begin
            // A delimiter where a service byte belongs restarts quietly.
            if (b == delim_reg) begin
               restart_scan();
               advance = 1'b0;
            end else if (!accept_offset(b)) begin
               word = {b, ST_ERR};
               produced = 1'b1;
               scan = SKIP_FRAME;
               advance = 1'b0;
            end
         end
         IN_BLOCK: begin
            // The delimiter must never show up inside the data.
            if (b == delim_reg) begin
               word = {b, ST_ERR};
               produced = 1'b1;
               scan = SKIP_FRAME;
               advance = 1'b0;
            end else begin
               word = {b, ST_OK};
               produced = 1'b1;
            end
         end
         AT_SWAP: begin
            // At a swap position the delimiter closes the frame; any other
            // byte is the next offset and the delimiter value is restored.
            if (b == delim_reg) begin
               word = {b, ST_END};
               produced = 1'b1;
               restart_scan();
               advance = 1'b0;
            end else if (!accept_offset(b)) begin
               word = {b, ST_ERR};
               produced = 1'b1;
               scan = SKIP_FRAME;
               advance = 1'b0;
            end else begin
               word = {delim_reg, ST_OK};
               produced = 1'b1;
            end
         end
         default: begin
            // After an error everything up to the next delimiter is dropped.
            if (b == delim_reg)
               restart_scan();
            advance = 1'b0;
         end
      endcase
      if (advance) begin
         // The service countdown wins when both counters expire together.
         service_left = service_left - 8'd1;
         swap_left = swap_left - 8'd1;
         if (service_left == 8'h00) begin
            scan = AWAIT_SERVICE;
            service_left = depth_reg;
         end else if (swap_left == 8'h00) begin
            scan = AT_SWAP;
         end else begin
            scan = IN_BLOCK;
         end
      end
      return produced;
   endfunction

   function automatic void note_mismatch(input string what, input decoded_type want,
                                         input decoded_type got);
      if (mismatch_count < 10)
         $display("%0t: %s: expected byte %02h status %0d, got byte %02h status %0d",
                  $realtime, what, want.out_byte, want.status, got.out_byte, got.status);
      mismatch_count++;
   endfunction

   // Byte driver. A word is held on req_chan until it is taken; only then
   // may the next one, or an idle burst, follow.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.in_byte <= '0;
      end else if (!req_chan.valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            send_gap = $urandom_range(0, 18);
            req_chan.valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_chan.valid <= 1'b1;
            req_chan.in_byte <= pending_bytes.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure: ready drops in bursts started at random.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 18);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Monitor. Every byte word taken by the block runs through the predictor;
   // every result word taken from the block is checked against the oldest
   // expectation.
   always @(posedge clock) begin : monitor
      decoded_type want;
      decoded_type got;
      bit          produced;
      if (reset) begin
         req_took <= 1'b0;
         delim_reg = DELIMITER_RESET;
         depth_reg = DEPTH_RESET;
         restart_scan();
      end else begin
         req_took <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            produced = decode_byte(req_chan.in_byte, want);
            if (produced)
               expected_decodes.push_back(want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.out_byte = rsp_chan.out_byte;
            got.status = rsp_chan.status;
            if (expected_decodes.size() == 0) begin
               note_mismatch("result word with nothing expected", '0, got);
            end else begin
               want = expected_decodes.pop_front();
               if (got.out_byte !== want.out_byte || got.status !== want.status)
                  note_mismatch("result word differs", want, got);
            end
         end
      end
   end

   task automatic send(input octet_type b);
      pending_bytes.push_back(b);
      queued_bytes++;
   endtask

   // Waits until every byte has been taken and every expected word has
   // arrived, then lets the clock run on for bytes that produce no word but
   // may still sit in the pipeline.
   task automatic await_drained();
      while (pending_bytes.size() > 0 || req_chan.valid || expected_decodes.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input octet_type value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DELIMITER)
         delim_reg = value;
      else
         depth_reg = value;
   endtask

   // Registers are only written while the decoder is idle.
   task automatic apply_setting(input octet_type delim, input octet_type depth);
      await_drained();
      write_csr(CSR_DELIMITER, delim);
      write_csr(CSR_DEPTH, depth);
   endtask

   // Offsets are mostly short so that swap positions come often. Now and
   // then the offset equals the delimiter, which must go out as a zero byte.
   function automatic int pick_offset();
      int top;
      top = (depth_reg < 8) ? int'(depth_reg) : 8;
      if (delim_reg != 8'h00 && $urandom_range(0, 15) == 0)
         return int'(delim_reg);
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(1, depth_reg);
      return $urandom_range(1, top);
   endfunction

   // Builds one encoded frame for the current delimiter and depth, starting
   // from the service position. A frame closes with the delimiter at a swap
   // position, or at a service position once the payload is used up. A
   // damaged frame gets one byte replaced and two trailing delimiters, which
   // bring the decoder back to the service position whatever happened.
   task automatic queue_frame(input bit damaged);
      octet_type frame[$];
      octet_type b;
      int        budget;
      int        to_service;
      int        to_swap;
      int        offset;
      int        spot;
      bit        done;
      budget = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300)
                                             : $urandom_range(0, 12);
      to_service = 0;
      to_swap = 1;
      done = 1'b0;
      while (!done) begin
         if (to_service == 0 || to_swap == 0) begin
            if (budget == 0) begin
               frame.push_back(delim_reg);
               done = 1'b1;
            end else begin
               offset = pick_offset();
               frame.push_back((offset == int'(delim_reg)) ? 8'h00 : octet_type'(offset));
               if (to_service == 0)
                  to_service = depth_reg;
               to_swap = offset;
            end
         end else begin
            do
               b = octet_type'($urandom);
            while (b == delim_reg);
            frame.push_back(b);
         end
         if (!done) begin
            to_service--;
            to_swap--;
            if (budget > 0)
               budget--;
         end
      end
      if (damaged) begin
         spot = $urandom_range(0, frame.size() - 1);
         case ($urandom_range(0, 2))
            0: frame[spot] = delim_reg;
            1: frame[spot] = (depth_reg == 8'hFF)
                  ? octet_type'($urandom)
                  : octet_type'($urandom_range(depth_reg + 1, 255));
            default: frame[spot] = octet_type'($urandom);
         endcase
         frame.push_back(delim_reg);
         frame.push_back(delim_reg);
      end
      foreach (frame[i])
         send(frame[i]);
   endtask

   // One random phase under a given setting. It opens with a delimiter so
   // that the new depth is loaded before the first block. Halfway through,
   // the sender stops until every expected word has come back.
   task automatic run_phase(input octet_type delim, input octet_type depth,
                            input int unsigned pct, input int unsigned count);
      int unsigned start;
      int unsigned roll;
      bit          held;
      apply_setting(delim, depth);
      idle_pct = pct;
      send(delim_reg);
      start = queued_bytes;
      held = 1'b0;
      while (queued_bytes - start < count) begin
         if (!held && queued_bytes - start >= count / 2) begin
            await_drained();
            held = 1'b1;
         end
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            queue_frame(1'b0);
         end else if (roll < 90) begin
            queue_frame(1'b1);
         end else begin
            // Line noise, then two delimiters to resynchronize.
            repeat ($urandom_range(1, 6))
               send(octet_type'($urandom));
            send(delim_reg);
            send(delim_reg);
         end
      end
   endtask

   initial begin
      // Directed bytes under the reset setting (delimiter 0, depth 255):
      // a delimiter as service byte, a plain frame, a frame with a restored
      // delimiter in the middle, and a delimiter inside the data followed
      // by a dropped byte and the recovering delimiter.
      octet_type reset_seq[] = '{8'h00,
                                 8'h03, 8'hFF, 8'h01, 8'h00,
                                 8'h02, 8'h80, 8'h02, 8'h7F, 8'h00,
                                 8'h03, 8'h11, 8'h00, 8'h33, 8'h00};
      // Directed bytes with delimiter A5 and depth 4: a restart that loads
      // the new depth, a service offset above the depth, a zero offset that
      // stands for the delimiter and runs past a block boundary, and a swap
      // offset above the depth.
      octet_type small_seq[] = '{8'hA5,
                                 8'h05, 8'h12, 8'hA5,
                                 8'h00, 8'h01, 8'h02, 8'h03, 8'h02, 8'hA4, 8'hA5,
                                 8'h01, 8'h09, 8'hA5};

      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.in_byte = '0;
      rsp_chan.ready = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 20;
      foreach (reset_seq[i])
         send(reset_seq[i]);
      apply_setting(8'hA5, 8'd4);
      foreach (small_seq[i])
         send(small_seq[i]);

      // Random phases, the register extremes among them.
      run_phase(8'h00, 8'd255, 10, 160);
      run_phase(8'hFF, 8'd1, 25, 120);
      run_phase(8'h7E, 8'd2, 40, 160);
      run_phase(8'h00, 8'd3, 15, 160);
      run_phase(8'hFF, 8'd255, 5, 160);
      run_phase(octet_type'($urandom), octet_type'($urandom_range(1, 16)), 20, 160);
      run_phase(octet_type'($urandom), octet_type'($urandom_range(1, 255)), 30, 160);
      // The last stretch runs back to back with no idling on either side.
      run_phase(octet_type'($urandom), octet_type'($urandom_range(4, 32)), 0, 160);

      await_drained();
      if (mismatch_count == 0 && expected_decodes.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
